// ===== rtl/ttpc_pkg.sv =====
package ttpc_pkg;

  localparam int ACCEL_BITS   = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;

  // CORDIC working width: sample scaled by 2^24 plus growth headroom.
  localparam int CW  = ACCEL_BITS + 24 + 3;
  // Squares and their sums.
  localparam int SQW = 2 * ACCEL_BITS + 2;
  // Square root result width.
  localparam int RTW = ACCEL_BITS + 1;
  localparam int STW = $clog2(CORDIC_STEPS + 1);

  localparam logic signed [11:0] YAW_LIMIT  = 12'sd1280;
  localparam logic [9:0]         PITCH_MAX  = 10'd900;
  localparam logic [9:0]         PITCH_HOME = 10'd450;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_ROLL_SPAN = 2'd1;
  localparam logic [1:0] REG_TILT_SPAN = 2'd2;
  localparam logic [1:0] REG_MIN_MAG   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ISQRT,
    ST_TILT_INIT,
    ST_TILT_RUN,
    ST_ROLL_INIT,
    ST_ROLL_RUN,
    ST_DELTA,
    ST_DIV,
    ST_SMOOTH,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic square;
    logic sqrt_step;
    logic tilt_init;
    logic roll_init;
    logic cordic_step;
    logic tilt_store;
    logic delta;
    logic div_start;
    logic div_step;
    logic smooth;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic use_sample;
    logic sqrt_done;
    logic cordic_done;
    logic div_done;
  } status_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t [TABLE_LEN];
    t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
          32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
          32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
          32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
          32'd81};
    return t[i];
  endfunction

endpackage

// ===== rtl/tilt_to_pan_tilt_command_unit.sv =====
// Tilt to pan/tilt command unit.
// Input channel (in_valid/in_ready) takes one word: kind and three signed
// accelerometer axes at 4096 per g. Kind 1 recalibrates the neutral pose.
// Output channel (out_valid/out_ready) gives one word per input: smoothed
// yaw and pitch commands, a used flag and the neutral-latched flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) and is
// to be written only while the unit is idle; the unit does not enforce this.
// Sequence for a used sample from acceptance to out_valid: the squares, the
// bit-serial square root (load, 17 steps, finish), the shared CORDIC run twice
// (load, 16 rotations, finish), the deltas, the two restoring dividers and
// smoothing. A rejected or ignored sample goes from the square root state
// straight to smoothing.
// One word is in flight at a time; in_ready is high only when idle, so a new
// word is accepted only after the previous result has been taken.
// When the receiver stalls the result is held in the output register and
// no new word is accepted until it is taken.
// Reset is synchronous: the state and configuration registers return to their
// defaults, the neutral pose is cleared and the pose goes home to yaw 0, pitch 450.
module tilt_to_pan_tilt_command_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [14:0]                            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  logic signed [ttpc_pkg::ACCEL_BITS-1:0] in_accel_x,
  input  logic signed [ttpc_pkg::ACCEL_BITS-1:0] in_accel_y,
  input  logic signed [ttpc_pkg::ACCEL_BITS-1:0] in_accel_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [11:0]                     out_yaw_cmd,
  output logic [9:0]                             out_pitch_cmd,
  output logic                                   out_sample_ok,
  output logic                                   out_neutral_set
);
  import ttpc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Sequencer.
  ttpc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  // Arithmetic.
  ttpc_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_wdata,
    .in_kind, .in_accel_x, .in_accel_y, .in_accel_z,
    .out_yaw_cmd, .out_pitch_cmd, .out_sample_ok, .out_neutral_set
  );

endmodule

// ===== rtl/ttpc_ctrl.sv =====
module ttpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ttpc_pkg::status_t sts,
  output ttpc_pkg::cmd_t    cmd
);
  import ttpc_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_SQUARE;
      ST_SQUARE:    state_nxt = ST_ISQRT;
      ST_ISQRT: begin
        if (!sts.use_sample) state_nxt = ST_SMOOTH;
        else if (sts.sqrt_done) state_nxt = ST_TILT_INIT;
      end
      ST_TILT_INIT: state_nxt = ST_TILT_RUN;
      ST_TILT_RUN:  if (sts.cordic_done) state_nxt = ST_ROLL_INIT;
      ST_ROLL_INIT: state_nxt = ST_ROLL_RUN;
      ST_ROLL_RUN:  if (sts.cordic_done) state_nxt = ST_DELTA;
      ST_DELTA:     state_nxt = ST_DIV;
      ST_DIV:       if (sts.div_done) state_nxt = ST_SMOOTH;
      ST_SMOOTH:    state_nxt = ST_DONE;
      ST_DONE:      if (out_ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQUARE:    cmd.square = 1'b1;
      ST_ISQRT:     cmd.sqrt_step = sts.use_sample;
      ST_TILT_INIT: cmd.tilt_init = 1'b1;
      ST_TILT_RUN: begin
        cmd.cordic_step = !sts.cordic_done;
        cmd.tilt_store  = sts.cordic_done;
      end
      ST_ROLL_INIT: cmd.roll_init = 1'b1;
      ST_ROLL_RUN:  cmd.cordic_step = !sts.cordic_done;
      ST_DELTA: begin
        cmd.delta     = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIV:       cmd.div_step = !sts.div_done;
      ST_SMOOTH: begin
        cmd.smooth   = 1'b1;
        cmd.out_load = 1'b1;
      end
      ST_DONE:      out_valid = 1'b1;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== rtl/ttpc_dp.sv =====
module ttpc_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ttpc_pkg::cmd_t                         cmd,
  output ttpc_pkg::status_t                      sts,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [14:0]                            cfg_wdata,
  input  logic                                   in_kind,
  input  logic signed [ttpc_pkg::ACCEL_BITS-1:0] in_accel_x,
  input  logic signed [ttpc_pkg::ACCEL_BITS-1:0] in_accel_y,
  input  logic signed [ttpc_pkg::ACCEL_BITS-1:0] in_accel_z,
  output logic signed [11:0]                     out_yaw_cmd,
  output logic [9:0]                             out_pitch_cmd,
  output logic                                   out_sample_ok,
  output logic                                   out_neutral_set
);
  import ttpc_pkg::*;

  localparam int AW = ANGLE_BITS;

  // Configuration registers.
  logic        enable_r;
  logic [14:0] roll_span_r, tilt_span_r;
  logic [12:0] min_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      roll_span_r <= 15'd6258;
      tilt_span_r <= 15'd7301;
      min_mag_r   <= 13'd205;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:    enable_r    <= cfg_wdata[0];
        REG_ROLL_SPAN: roll_span_r <= cfg_wdata;
        REG_TILT_SPAN: tilt_span_r <= cfg_wdata;
        REG_MIN_MAG:   min_mag_r   <= cfg_wdata[12:0];
        default:       enable_r    <= enable_r;
      endcase
    end
  end

  // Latched word.
  logic                         kind_r;
  logic signed [ACCEL_BITS-1:0] ax_r, ay_r, az_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      ax_r   <= in_accel_x;
      ay_r   <= in_accel_y;
      az_r   <= in_accel_z;
    end
  end

  // Squares, magnitude test.
  logic signed [2*ACCEL_BITS-1:0] sq_x, sq_y, sq_z;
  assign sq_x = ax_r * ax_r;
  assign sq_y = ay_r * ay_r;
  assign sq_z = az_r * az_r;

  logic [SQW-1:0] yz2_r, mag2_r, min2_r;
  logic           use_r;
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      yz2_r  <= SQW'(unsigned'(sq_y)) + SQW'(unsigned'(sq_z));
      mag2_r <= SQW'(unsigned'(sq_x));
      min2_r <= SQW'(min_mag_r * min_mag_r);
    end
  end
  // Magnitude sum is formed from the registered squares, in the cycle after them, to keep one add per stage.
  logic [SQW-1:0] mag_full;
  assign mag_full = mag2_r + yz2_r;
  assign use_r = (mag_full >= min2_r) && (kind_r || enable_r);
  assign sts.use_sample = use_r;

  // Integer square root, one result bit per cycle.
  localparam int SQW2 = SQW + (SQW % 2);
  localparam int SQ_ITERS = SQW2 / 2;
  logic [RTW-1:0]  root_r;
  logic            sq_busy_r;

  // Restoring square root kept as partial remainder and shifting radicand.
  logic [SQW2-1:0] rad_r;
  logic [RTW+1:0]  prem_r;
  logic [RTW+1:0]  prem_sh, ptrial;
  logic [$clog2(SQ_ITERS+1)-1:0] sqi_r;
  assign prem_sh = {prem_r[RTW-1:0], rad_r[SQW2-1 -: 2]};
  assign ptrial  = {root_r[RTW-1:0], 2'b01};
  assign sts.sqrt_done = sq_busy_r && (sqi_r == ($clog2(SQ_ITERS+1))'(SQ_ITERS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.square) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sqrt_step) begin
      sq_busy_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_step && !sq_busy_r) begin
      rad_r  <= SQW2'(yz2_r);
      prem_r <= '0;
      root_r <= '0;
      sqi_r  <= '0;
    end else if (cmd.sqrt_step && !sts.sqrt_done) begin
      rad_r <= rad_r << 2;
      sqi_r <= sqi_r + 1'b1;
      if (prem_sh >= ptrial) begin
        prem_r <= prem_sh - ptrial;
        root_r <= {root_r[RTW-2:0], 1'b1};
      end else begin
        prem_r <= prem_sh;
        root_r <= {root_r[RTW-2:0], 1'b0};
      end
    end
  end

  // Shared vectoring CORDIC.
  logic signed [CW-1:0] cx_r, cy_r;
  logic [31:0]          acc_r;
  logic [STW-1:0]       step_r;
  logic                 czero_r;
  logic signed [CW-1:0] init_c, init_s;

  always_comb begin
    if (cmd.tilt_init) begin
      init_c = CW'(ay_r) <<< 24;
      init_s = CW'(az_r) <<< 24;
    end else begin
      init_c = CW'($signed({1'b0, root_r})) <<< 24;
      init_s = CW'(ax_r) <<< 24;
    end
  end

  assign sts.cordic_done = (step_r == STW'(CORDIC_STEPS));

  always_ff @(posedge clk) begin
    if (cmd.tilt_init || cmd.roll_init) begin
      czero_r <= (init_c == '0) && (init_s == '0);
      step_r  <= '0;
      if (init_c < 0) begin
        cx_r  <= -init_c;
        cy_r  <= -init_s;
        acc_r <= 32'h8000_0000;
      end else begin
        cx_r  <= init_c;
        cy_r  <= init_s;
        acc_r <= '0;
      end
    end else if (cmd.cordic_step) begin
      step_r <= step_r + 1'b1;
      if (cy_r > 0) begin
        cx_r  <= cx_r + (cy_r >>> step_r);
        cy_r  <= cy_r - (cx_r >>> step_r);
        acc_r <= acc_r + atan_turn(int'(step_r));
      end else begin
        cx_r  <= cx_r - (cy_r >>> step_r);
        cy_r  <= cy_r + (cx_r >>> step_r);
        acc_r <= acc_r - atan_turn(int'(step_r));
      end
    end
  end

  logic [31:0]   acc_rnd;
  logic [AW-1:0] angle;
  assign acc_rnd = acc_r + (32'd1 << (31 - AW));
  assign angle   = czero_r ? '0 : acc_rnd[31 -: AW];

  logic [AW-1:0] tilt_r;
  always_ff @(posedge clk) begin
    if (cmd.tilt_store) tilt_r <= angle;
  end

  // Neutral angles and pose state.
  logic [AW-1:0]      nroll_r, ntilt_r;
  logic               nvalid_r;
  logic signed [11:0] yaw_r;
  logic [9:0]         pitch_r;

  // Deltas and clamp.
  logic [14:0] rs, ts;
  assign rs = (roll_span_r == '0) ? 15'd1 : roll_span_r;
  assign ts = (tilt_span_r == '0) ? 15'd1 : tilt_span_r;

  logic [AW-1:0]        nr_eff, nt_eff;
  logic signed [AW-1:0] dr_w, dt_w;
  logic signed [AW+1:0] dr_c, dt_c, rs_s, ts_s;
  assign nr_eff = nvalid_r ? nroll_r : angle;
  assign nt_eff = nvalid_r ? ntilt_r : tilt_r;
  assign dr_w = $signed(angle - nr_eff);
  assign dt_w = $signed(tilt_r - nt_eff);
  assign rs_s = $signed({3'b000, rs});
  assign ts_s = $signed({3'b000, ts});
  always_comb begin
    dr_c = (AW+2)'(dr_w);
    dt_c = (AW+2)'(dt_w);
    if (dr_c > rs_s) dr_c = rs_s;
    else if (dr_c < -rs_s) dr_c = -rs_s;
    if (dt_c > ts_s) dt_c = ts_s;
    else if (dt_c < -ts_s) dt_c = -ts_s;
  end

  // Two restoring dividers: (2|d|*K + s) / (2s), both quotients under 2^11.
  localparam int NW = 28;
  localparam int QB = 12;
  logic [NW-1:0] rn_r, tn_r;
  logic [NW-1:0] rrem_r, trem_r;
  logic [15:0]   rden_r, tden_r;
  logic [QB-1:0] rq_r, tq_r;
  logic          rneg_r, tneg_r;
  logic [3:0]    dcnt_r;
  logic [AW+1:0] dr_abs, dt_abs;
  logic [NW-1:0] rnum, tnum;
  assign dr_abs = dr_c < 0 ? unsigned'(-dr_c) : unsigned'(dr_c);
  assign dt_abs = dt_c < 0 ? unsigned'(-dt_c) : unsigned'(dt_c);
  assign rnum   = NW'(dr_abs) * NW'(2560) + NW'(rs);
  assign tnum   = NW'(dt_abs) * NW'(900) + NW'(ts);
  assign sts.div_done = (dcnt_r == 4'(QB));

  logic [NW-1:0] rrem_sh, trem_sh;
  logic [NW-1:0] rden_w, tden_w;
  assign rden_w  = NW'(rden_r);
  assign tden_w  = NW'(tden_r);
  assign rrem_sh = {rrem_r[NW-2:0], rn_r[NW-1]};
  assign trem_sh = {trem_r[NW-2:0], tn_r[NW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // The upper bits start the remainder; the low QB bits are shifted in.
      rn_r   <= rnum << (NW - QB);
      tn_r   <= tnum << (NW - QB);
      rrem_r <= rnum >> QB;
      trem_r <= tnum >> QB;
      rden_r <= {rs, 1'b0};
      tden_r <= {ts, 1'b0};
      rneg_r <= dr_c < 0;
      tneg_r <= dt_c < 0;
      rq_r   <= '0;
      tq_r   <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      rn_r   <= rn_r << 1;
      tn_r   <= tn_r << 1;
      if (rrem_sh >= rden_w) begin
        rrem_r <= rrem_sh - rden_w;
        rq_r   <= {rq_r[QB-2:0], 1'b1};
      end else begin
        rrem_r <= rrem_sh;
        rq_r   <= {rq_r[QB-2:0], 1'b0};
      end
      if (trem_sh >= tden_w) begin
        trem_r <= trem_sh - tden_w;
        tq_r   <= {tq_r[QB-2:0], 1'b1};
      end else begin
        trem_r <= trem_sh;
        tq_r   <= {tq_r[QB-2:0], 1'b0};
      end
    end
  end

  // Targets.
  logic signed [13:0] ty, tp, dy, dp;
  always_comb begin
    ty = rneg_r ? -$signed({2'b00, rq_r}) : $signed({2'b00, rq_r});
    if (ty > 14'sd1280) ty = 14'sd1280;
    else if (ty < -14'sd1280) ty = -14'sd1280;
    tp = 14'sd450 - (tneg_r ? -$signed({2'b00, tq_r}) : $signed({2'b00, tq_r}));
    if (tp > 14'sd900) tp = 14'sd900;
    else if (tp < 14'sd0) tp = 14'sd0;
  end
  assign dy = ty - 14'(yaw_r);
  assign dp = tp - $signed({4'b0000, pitch_r});

  // A third of the difference, truncated toward zero, by reciprocal multiply.
  // The product is exact for magnitudes below 2^17.
  function automatic logic signed [13:0] third(input logic signed [13:0] d);
    logic [13:0] a;
    logic [30:0] p;
    a = d < 0 ? 14'(-d) : 14'(d);
    p = 31'(a) * 31'(17'd43691);
    return d < 0 ? -$signed({1'b0, p[29:17]}) : $signed({1'b0, p[29:17]});
  endfunction

  function automatic logic signed [13:0] smooth_step(input logic signed [13:0] cur,
                                                     input logic signed [13:0] tgt,
                                                     input logic signed [13:0] d);
    if (d > -14'sd4 && d < 14'sd4) return tgt;
    return cur + third(d);
  endfunction

  logic signed [13:0] yaw_n, pitch_n;
  assign yaw_n   = smooth_step(14'(yaw_r), ty, dy);
  assign pitch_n = smooth_step($signed({4'b0000, pitch_r}), tp, dp);

  // Angles held across the divide.
  logic [AW-1:0] nr_eff_hold, nt_hold;
  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      nr_eff_hold <= angle;
      nt_hold     <= tilt_r;
    end
  end

  // Pose and neutral update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nroll_r  <= '0;
      ntilt_r  <= '0;
      nvalid_r <= 1'b0;
      yaw_r    <= '0;
      pitch_r  <= PITCH_HOME;
    end else if (cmd.smooth) begin
      if (kind_r) begin
        if (use_r) begin
          nroll_r  <= nr_eff_hold;
          ntilt_r  <= nt_hold;
        end
        nvalid_r <= use_r;
        yaw_r    <= '0;
        pitch_r  <= PITCH_HOME;
      end else if (use_r) begin
        if (!nvalid_r) begin
          nroll_r <= nr_eff_hold;
          ntilt_r <= nt_hold;
        end
        nvalid_r <= 1'b1;
        yaw_r    <= yaw_n[11:0];
        pitch_r  <= pitch_n[9:0];
      end
    end
  end

  // Output register.
  logic ok_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) ok_r <= use_r;
  end
  assign out_yaw_cmd     = yaw_r;
  assign out_pitch_cmd   = pitch_r;
  assign out_sample_ok   = ok_r;
  assign out_neutral_set = nvalid_r;

endmodule

// ===== rtl/ttpc_checker.sv =====
module ttpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_pitch_cmd,
  input logic [11:0] out_yaw_cmd
);
  // Only one word in flight: no input taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pitch_cmd) &&
    $stable(out_yaw_cmd))
    else $error("result changed under stall");

  // Pitch stays in range.
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_cmd <= 10'd900) else $error("pitch out of range");

  // An accepted input never shows a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

endmodule

bind tilt_to_pan_tilt_command_unit ttpc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_pitch_cmd, .out_yaw_cmd
);

// ===== tb/tilt_to_pan_tilt_command_unit_tb.sv =====
module tilt_to_pan_tilt_command_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttpc_pkg::*;

  typedef struct {
    logic signed [11:0] yaw;
    logic [9:0]         pitch;
    logic               ok;
    logic               neutral;
  } pose_word_t;

  // Pose tracker: mirrors the command unit and checks its output words in order.
  class pose_scoreboard;
    pose_word_t pending[$];
    int errors = 0;
    int checked = 0;
    int used_count = 0;
    bit         enable;
    bit [14:0]  roll_span, tilt_span;
    bit [12:0]  min_mag;
    bit [15:0]  neutral_roll, neutral_tilt;
    bit         neutral_valid;
    int         cur_yaw, cur_pitch;

    function new();
      enable = 0; roll_span = 6258; tilt_span = 7301; min_mag = 205;
      neutral_roll = 0; neutral_tilt = 0; neutral_valid = 0;
      cur_yaw = 0; cur_pitch = 450;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        REG_ENABLE:    enable = val[0];
        REG_ROLL_SPAN: roll_span = val;
        REG_TILT_SPAN: tilt_span = val;
        REG_MIN_MAG:   min_mag = val[12:0];
        default: ;
      endcase
    endfunction

    // Floor of the square root, bit by bit.
    function longint unsigned floor_root(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // Vectoring rotation: binary angle of (c, s), rounded half up.
    function bit [15:0] vector_angle(longint s, longint c);
      longint x, y, nx;
      bit [31:0] acc;
      acc = 0;
      if (s == 0 && c == 0) return 16'd0;
      x = c * (64'sd1 <<< 24);
      y = s * (64'sd1 <<< 24);
      if (x < 0) begin
        x = -x; y = -y; acc = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          acc += atan_table(i);
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          acc -= atan_table(i);
        end
        x = nx;
      end
      acc += 32'd1 << (31 - ANGLE_BITS);
      return acc[31:16];
    endfunction

    function bit [31:0] atan_table(int i);
      bit [31:0] t [16];
      t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
            32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
            32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};
      return t[i];
    endfunction

    function int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function int round_away_div(longint n, longint d);
      longint a, q;
      a = n < 0 ? -n : n;
      q = (2 * a + d) / (2 * d);
      return int'(n < 0 ? -q : q);
    endfunction

    function int ease(int cur, int target);
      int diff;
      diff = target - cur;
      if (diff > -4 && diff < 4) return target;
      return cur + diff / 3;
    endfunction

    // Predicts the word for one accepted input and queues it.
    function void note_word(bit kind, logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az);
      longint yz2, mag2, min2;
      bit used;
      bit [15:0] tilt, roll;
      int rs, ts, dr, dt, ty, tp;
      pose_word_t w;
      yz2  = longint'(ay) * ay + longint'(az) * az;
      mag2 = yz2 + longint'(ax) * ax;
      min2 = longint'(min_mag) * min_mag;
      used = 0; tilt = 0; roll = 0;
      if (mag2 >= min2 && (kind || enable)) begin
        tilt = vector_angle(az, ay);
        roll = vector_angle(ax, longint'(floor_root(yz2)));
        used = 1;
      end
      if (kind) begin
        if (used) begin
          neutral_roll = roll; neutral_tilt = tilt; neutral_valid = 1;
        end else begin
          neutral_valid = 0;
        end
        cur_yaw = 0; cur_pitch = 450;
      end else if (used) begin
        rs = roll_span == 0 ? 1 : int'(roll_span);
        ts = tilt_span == 0 ? 1 : int'(tilt_span);
        if (!neutral_valid) begin
          neutral_roll = roll; neutral_tilt = tilt; neutral_valid = 1;
        end
        dr = clampi(int'($signed(16'(roll - neutral_roll))), -rs, rs);
        dt = clampi(int'($signed(16'(tilt - neutral_tilt))), -ts, ts);
        ty = clampi(round_away_div(longint'(dr) * 1280, rs), -1280, 1280);
        tp = clampi(450 - round_away_div(longint'(dt) * 450, ts), 0, 900);
        cur_yaw = ease(cur_yaw, ty);
        cur_pitch = ease(cur_pitch, tp);
      end
      w.yaw = cur_yaw[11:0];
      w.pitch = cur_pitch[9:0];
      w.ok = used;
      w.neutral = neutral_valid;
      pending.push_back(w);
    endfunction

    function void check_word(logic signed [11:0] yaw, logic [9:0] pitch, logic ok,
                             logic neutral);
      pose_word_t e;
      if (pending.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ok === 1'b1) used_count++;
      if (yaw !== e.yaw) begin
        $error("yaw_cmd: expected %0d, got %0d", e.yaw, yaw); errors++;
      end
      if (pitch !== e.pitch) begin
        $error("pitch_cmd: expected %0d, got %0d", e.pitch, pitch); errors++;
      end
      if (ok !== e.ok) begin
        $error("sample_ok: expected %0d, got %0d", e.ok, ok); errors++;
      end
      if (neutral !== e.neutral) begin
        $error("neutral_set: expected %0d, got %0d", e.neutral, neutral); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [14:0] cfg_wdata;
  logic in_valid, in_ready, in_kind;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic out_valid, out_ready;
  logic signed [11:0] out_yaw_cmd;
  logic [9:0] out_pitch_cmd;
  logic out_sample_ok, out_neutral_set;

  pose_scoreboard sb;
  bit no_gaps;
  int words_sent;

  tilt_to_pan_tilt_command_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Check every word taken from the output.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_yaw_cmd, out_pitch_cmd, out_sample_ok, out_neutral_set);
  end

  // Receiver: mostly ready, with short and occasional long stalls.
  initial begin
    int r, n;
    out_ready = 0;
    forever begin
      r = $urandom_range(0, 99);
      n = r < 55 ? 0 : (r < 92 ? $urandom_range(1, 4) : $urandom_range(20, 80));
      if (n > 0) begin
        @(negedge clk) out_ready <= 0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  end

  function automatic int sender_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    return r < 50 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 50));
  endfunction

  // Presents one word, holds it until taken, then idles for a random gap, which may be zero.
  task automatic send_word(bit kind, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z);
    int gap;
    @(negedge clk);
    in_valid <= 1; in_kind <= kind;
    in_accel_x <= x; in_accel_y <= y; in_accel_z <= z;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_word(kind, x, y, z);
    words_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every expected word has come and the unit has settled.
  task automatic drain();
    @(negedge clk) in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk) cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(bit en, logic [14:0] rs, logic [14:0] ts, logic [14:0] mm);
    write_reg(REG_ENABLE, 15'(en));
    write_reg(REG_ROLL_SPAN, rs);
    write_reg(REG_TILT_SPAN, ts);
    write_reg(REG_MIN_MAG, mm);
  endtask

  function automatic logic signed [15:0] near_g();
    return 16'($signed($urandom_range(0, 9000)) - 4500);
  endfunction

  // Random words: mostly plausible hand poses, some recalibrates, weak and wild samples.
  task automatic random_words(int count);
    int r;
    logic signed [15:0] bx, by, bz;
    bx = near_g(); by = near_g(); bz = 16'sd4096;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        send_word(1'b1, near_g(), near_g(), near_g());
      else if (r < 12)
        send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 18)
        send_word(1'b0, 16'($signed($urandom_range(0, 400)) - 200),
                  16'($signed($urandom_range(0, 400)) - 200),
                  16'($signed($urandom_range(0, 400)) - 200));
      else begin
        if ($urandom_range(0, 19) == 0) begin
          bx = near_g(); by = near_g(); bz = near_g();
        end
        bx = bx + 16'($signed($urandom_range(0, 600)) - 300);
        by = by + 16'($signed($urandom_range(0, 600)) - 300);
        bz = bz + 16'($signed($urandom_range(0, 600)) - 300);
        send_word(1'b0, bx, by, bz);
      end
    end
  endtask

  initial begin
    sb = new();
    words_sent = 0;
    no_gaps = 0;
    rst_n = 0; cfg_we = 0; cfg_index = REG_ENABLE; cfg_wdata = 0;
    in_valid = 0; in_kind = 0; in_accel_x = 0; in_accel_y = 0; in_accel_z = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Disabled at reset: ordinary samples ignored, recalibrate still acts.
    send_word(1'b0, 16'sd0, 16'sd0, 16'sd4096);
    send_word(1'b1, 16'sd0, 16'sd0, 16'sd4096);
    send_word(1'b1, 16'sd10, 16'sd10, 16'sd10);
    drain();

    // Enabled: first good sample latches neutral, then extremes of each axis.
    write_reg(REG_ENABLE, 15'd1);
    send_word(1'b0, 16'sd0, 16'sd0, 16'sd4096);
    send_word(1'b0, 16'sd4096, 16'sd0, 16'sd4096);
    send_word(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(1'b0, -16'sd32768, -16'sd32768, -16'sd32768);
    send_word(1'b0, 16'sh7FFF, -16'sd32768, 16'sd0);
    send_word(1'b0, -16'sd32768, 16'sd0, -16'sd32768);
    send_word(1'b0, 16'sd0, -16'sd4096, -16'sd1);
    send_word(1'b0, 16'sd0, -16'sd4096, 16'sd1);
    send_word(1'b0, 16'sd100, 16'sd100, 16'sd100);
    send_word(1'b1, 16'sd1000, 16'sd0, -16'sd4096);
    send_word(1'b0, -16'sd3000, 16'sd2000, -16'sd3000);
    drain();

    // Zero minimum and zero spans: the zero vector is used, spans act as one.
    set_regs(1'b1, 15'd0, 15'd0, 15'd0);
    send_word(1'b0, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b0, 16'sd5, -16'sd7, 16'sd3);
    send_word(1'b0, -16'sd5, 16'sd7, -16'sd3);
    drain();

    // Largest minimum: samples at and just below it, a weak recalibrate and a strong sample.
    set_regs(1'b1, 15'd16384, 15'd16384, 15'd8191);
    send_word(1'b0, 16'sd8191, 16'sd0, 16'sd0);
    send_word(1'b0, 16'sd8190, 16'sd0, 16'sd0);
    send_word(1'b1, 16'sd100, 16'sd0, 16'sd0);
    send_word(1'b0, -16'sd32768, 16'sh7FFF, 16'sd0);
    drain();

    // Random phases over several settings.
    set_regs(1'b1, 15'd6258, 15'd7301, 15'd205);
    random_words(250);
    drain();
    no_gaps = 1;
    set_regs(1'b1, 15'd1, 15'd1, 15'd0);
    random_words(120);
    drain();
    no_gaps = 0;
    set_regs(1'b1, 15'd16384, 15'd16384, 15'd4000);
    random_words(120);
    drain();
    set_regs(1'b1, 15'($urandom_range(500, 3000)), 15'($urandom_range(500, 3000)),
             15'($urandom_range(0, 1000)));
    random_words(250);
    drain();
    set_regs(1'b0, 15'h7FFF, 15'h7FFF, 15'd205);
    random_words(60);
    drain();

    $display("Sent %0d words; %0d output words checked, %0d with the sample used.",
             words_sent, sb.checked, sb.used_count);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
